// File: rtl/mch_pkg.sv
`default_nettype none
package mch_pkg;

    localparam int CordicSteps = 16;
    localparam int MaxSteps = 24;
    localparam int NumSteps = (CordicSteps > MaxSteps) ? MaxSteps : CordicSteps;

    localparam int FieldW = 22;
    localparam int CordW = 24;

    localparam int DenTwo = 7680;
    localparam int DenOther = 1920;

    // ceil(2^29 / 15): exact floor division by 15 for numerators below 2^25
    localparam logic [25:0] Recip15 = 26'd35791395;
    localparam int Recip15Shift = 29;

    localparam logic [1:0] CODE_OK = 2'd0;
    localparam logic [1:0] CODE_NOT_READY = 2'd1;
    localparam logic [1:0] CODE_OVERFLOW = 2'd2;

    localparam logic [2:0] REG_RANGE = 3'd0;
    localparam logic [2:0] REG_OFS_X = 3'd1;
    localparam logic [2:0] REG_OFS_Y = 3'd2;
    localparam logic [2:0] REG_OFS_Z = 3'd3;
    localparam logic [2:0] REG_GAIN_X = 3'd4;
    localparam logic [2:0] REG_GAIN_Y = 3'd5;
    localparam logic [2:0] REG_GAIN_Z = 3'd6;
    localparam logic [2:0] REG_DECL = 3'd7;

    // arctangent of 2^-i, 2^32 per turn
    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] r;
        begin
            case (i)
                0: r = 32'd536870912;
                1: r = 32'd316933406;
                2: r = 32'd167458907;
                3: r = 32'd85004756;
                4: r = 32'd42667331;
                5: r = 32'd21354465;
                6: r = 32'd10679838;
                7: r = 32'd5340245;
                8: r = 32'd2670163;
                9: r = 32'd1335087;
                10: r = 32'd667544;
                11: r = 32'd333772;
                12: r = 32'd166886;
                13: r = 32'd83443;
                14: r = 32'd41722;
                15: r = 32'd20861;
                16: r = 32'd10430;
                17: r = 32'd5215;
                18: r = 32'd2608;
                19: r = 32'd1304;
                20: r = 32'd652;
                21: r = 32'd326;
                22: r = 32'd163;
                23: r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/mch_axis_lane.sv
`default_nettype none
// One axis: offset, gain multiply, rounded divide by range constant,
// saturate. Two registered stages, advancing on en.
module mch_axis_lane (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [15:0] raw,
    input  wire logic [15:0] offset,
    input  wire logic [15:0] gain,
    input  wire logic        two_gauss,
    output logic signed [mch_pkg::FieldW-1:0] field
);
    // stage 1: product magnitude
    logic        neg_reg;
    logic [31:0] mag_reg;
    logic        two1_reg;
    // stage 2: quotient
    logic        neg2_reg;
    logic [31:0] q_reg;
    logic signed [15:0] d;
    logic [15:0] dmag;
    logic [31:0] mag_next;
    logic [31:0] num;
    logic [31:0] t;
    logic [63:0] qa;
    logic [31:0] q_next;
    logic signed [32:0] sq;
    logic signed [32:0] lim_hi;
    logic signed [32:0] lim_lo;

    assign d = $signed(raw - offset);
    assign dmag = d[15] ? 16'(-d) : d;
    assign mag_next = 32'(dmag) * 32'(gain);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg <= d[15];
            mag_reg <= mag_next;
            two1_reg <= two_gauss;
        end
    end

    // divisor is 15 * 2^9 or 15 * 2^7: drop the power of two, then divide by 15
    always_comb
    begin
        num = mag_reg + (two1_reg ? 32'(mch_pkg::DenTwo / 2) : 32'(mch_pkg::DenOther / 2));
        t = two1_reg ? (num >> 9) : (num >> 7);
        qa = (64'(t) * 64'(mch_pkg::Recip15)) >> mch_pkg::Recip15Shift;
        q_next = qa[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg2_reg <= neg_reg;
            q_reg <= q_next;
        end
    end

    // apply sign and saturate
    always_comb
    begin
        sq = neg2_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        lim_hi = 33'sd2097151;
        lim_lo = -33'sd2097152;
        if (sq > lim_hi)
            field = mch_pkg::FieldW'(lim_hi);
        else if (sq < lim_lo)
            field = mch_pkg::FieldW'(lim_lo);
        else
            field = sq[mch_pkg::FieldW-1:0];
    end
endmodule
`default_nettype wire

// File: rtl/mch_cordic.sv
`default_nettype none
// Pipelined vectoring CORDIC, one stage per step; yields rounded heading.
module mch_cordic (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic signed [mch_pkg::FieldW-1:0] x_in,
    input  wire logic signed [mch_pkg::FieldW-1:0] y_in,
    output logic [15:0]      angle
);
    localparam int N = mch_pkg::NumSteps;
    localparam int W = mch_pkg::CordW;

    logic signed [W-1:0] x_reg [0:N];
    logic signed [W-1:0] y_reg [0:N];
    logic [31:0]         z_reg [0:N];
    logic                zero_reg [0:N];
    logic signed [W-1:0] x0;
    logic signed [W-1:0] y0;
    logic [31:0]         za;

    // pre-rotate left half plane
    always_comb
    begin
        x0 = W'(x_in);
        y0 = W'(y_in);
        if (x_in < 0)
        begin
            x0 = -W'(x_in);
            y0 = -W'(y_in);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x0;
            y_reg[0] <= y0;
            z_reg[0] <= (x_in < 0) ? 32'h8000_0000 : 32'h0;
            zero_reg[0] <= (x_in == 0) && (y_in == 0);
        end
    end

    // micro-rotation stages
    for (genvar i = 0; i < N; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + mch_pkg::atan_entry(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - mch_pkg::atan_entry(i);
                end
            end
        end
    end

    assign za = z_reg[N] + 32'h8000;
    assign angle = zero_reg[N] ? 16'd0 : za[31:16];
endmodule
`default_nettype wire

// File: rtl/magnetometer_calibrate_heading_unit.sv
`default_nettype none
// Magnetometer calibration and compass heading. Takes one sample word per
// cycle unless stalled; each word runs through three calibration lanes (x,
// y, z: offset, gain multiply, rounded scale, saturation, 2 register
// stages), then a pipelined CORDIC of CordicSteps+1 stages and the output
// register. The whole pipe stalls only when the output register is full
// and not taken. Results come out in input order.
module magnetometer_calibrate_heading_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // status_byte, x_low, x_high, y_low, y_high, z_low, z_high
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // result_code, field_x, field_y, field_z, heading_angle, 4 pad bits
    output logic [87:0]      m_tdata
);
    localparam int LAT = mch_pkg::NumSteps + 4;

    logic        range_reg;
    logic [15:0] ofs_x_reg, ofs_y_reg, ofs_z_reg;
    logic [15:0] gain_x_reg, gain_y_reg, gain_z_reg;
    logic [15:0] decl_reg;
    logic        wr;
    logic [2:0]  idx;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign idx = paddr[4:2];

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= 1'b0;
            ofs_x_reg <= '0;
            ofs_y_reg <= '0;
            ofs_z_reg <= '0;
            gain_x_reg <= 16'd16384;
            gain_y_reg <= 16'd16384;
            gain_z_reg <= 16'd16384;
            decl_reg <= '0;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            case (idx)
                mch_pkg::REG_RANGE: range_reg <= pwdata[0];
                mch_pkg::REG_OFS_X: ofs_x_reg <= pwdata[15:0];
                mch_pkg::REG_OFS_Y: ofs_y_reg <= pwdata[15:0];
                mch_pkg::REG_OFS_Z: ofs_z_reg <= pwdata[15:0];
                mch_pkg::REG_GAIN_X: gain_x_reg <= pwdata[15:0];
                mch_pkg::REG_GAIN_Y: gain_y_reg <= pwdata[15:0];
                mch_pkg::REG_GAIN_Z: gain_z_reg <= pwdata[15:0];
                mch_pkg::REG_DECL: decl_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            mch_pkg::REG_RANGE: prdata = {31'd0, range_reg};
            mch_pkg::REG_OFS_X: prdata = {16'd0, ofs_x_reg};
            mch_pkg::REG_OFS_Y: prdata = {16'd0, ofs_y_reg};
            mch_pkg::REG_OFS_Z: prdata = {16'd0, ofs_z_reg};
            mch_pkg::REG_GAIN_X: prdata = {16'd0, gain_x_reg};
            mch_pkg::REG_GAIN_Y: prdata = {16'd0, gain_y_reg};
            mch_pkg::REG_GAIN_Z: prdata = {16'd0, gain_z_reg};
            mch_pkg::REG_DECL: prdata = {16'd0, decl_reg};
            default: prdata = '0;
        endcase
    end

    // pipeline control: advance when the output slot is free or taken
    logic en;
    logic [LAT-1:0] vld_reg;
    logic [1:0] code_reg [0:LAT-2];
    logic [1:0] code_in;

    assign en = !m_tvalid || m_tready;
    assign s_tready = en;
    assign code_in = !s_tdata[0] ? mch_pkg::CODE_NOT_READY :
                     s_tdata[1] ? mch_pkg::CODE_OVERFLOW : mch_pkg::CODE_OK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            code_reg[0] <= code_in;
            for (int i = 1; i < LAT - 1; i++)
                code_reg[i] <= code_reg[i-1];
        end
    end

    // calibration lanes
    logic signed [mch_pkg::FieldW-1:0] fx, fy, fz;
    mch_axis_lane u_lx (.clk(clk), .en(en), .raw(s_tdata[23:8]), .offset(ofs_x_reg),
        .gain(gain_x_reg), .two_gauss(range_reg), .field(fx));
    mch_axis_lane u_ly (.clk(clk), .en(en), .raw(s_tdata[39:24]), .offset(ofs_y_reg),
        .gain(gain_y_reg), .two_gauss(range_reg), .field(fy));
    mch_axis_lane u_lz (.clk(clk), .en(en), .raw(s_tdata[55:40]), .offset(ofs_z_reg),
        .gain(gain_z_reg), .two_gauss(range_reg), .field(fz));

    // delay x, y and z alongside the CORDIC
    logic [mch_pkg::FieldW-1:0] fz_reg [0:mch_pkg::NumSteps];
    logic [mch_pkg::FieldW-1:0] fx_reg [0:mch_pkg::NumSteps];
    logic [mch_pkg::FieldW-1:0] fy_reg [0:mch_pkg::NumSteps];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fx_reg[0] <= fx;
            fy_reg[0] <= fy;
            fz_reg[0] <= fz;
            for (int i = 1; i <= mch_pkg::NumSteps; i++)
            begin
                fx_reg[i] <= fx_reg[i-1];
                fy_reg[i] <= fy_reg[i-1];
                fz_reg[i] <= fz_reg[i-1];
            end
        end
    end

    logic [15:0] ang;
    mch_cordic u_cordic (.clk(clk), .en(en), .x_in(fx), .y_in(fy), .angle(ang));

    // merge: output register
    logic [1:0] oc;
    logic [15:0] head;
    assign oc = code_reg[LAT-2];
    assign head = ang + decl_reg;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (oc == mch_pkg::CODE_OK)
                m_tdata <= {4'b0000, head, fz_reg[mch_pkg::NumSteps],
                            fy_reg[mch_pkg::NumSteps], fx_reg[mch_pkg::NumSteps], oc};
            else
                m_tdata <= {86'd0, oc};
        end
    end
endmodule
`default_nettype wire

// File: dv/tb.sv
`default_nettype none
module tb;
    import mch_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  code;
        logic [21:0] fx;
        logic [21:0] fy;
        logic [21:0] fz;
        logic [15:0] heading;
    } heading_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    // status_byte, x_low, x_high, y_low, y_high, z_low, z_high
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // result_code, field_x, field_y, field_z, heading_angle, 4 pad bits
    logic [87:0] m_tdata;

    magnetometer_calibrate_heading_unit dut (.*);

    // local copy of the calibration registers
    logic        cal_two_gauss;
    logic [15:0] cal_ofs [3];
    logic [15:0] cal_gain [3];
    logic [15:0] cal_decl;

    logic [55:0] sample_q [$];
    heading_t    heading_q [$];
    int          mismatches;
    bit          calm;
    bit          in_acc;
    int          tx_gap;
    int          rx_gap;

    function automatic longint scale_axis(logic [7:0] lo, logic [7:0] hi, int ax);
        logic [15:0] dw;
        longint d, p, den, q;
        dw = {hi, lo} - cal_ofs[ax];
        d = longint'($signed(dw));
        den = cal_two_gauss ? 7680 : 1920;
        p = d * longint'(cal_gain[ax]);
        if (p >= 0)
            q = (p + den / 2) / den;
        else
            q = -((-p + den / 2) / den);
        if (q > 2097151)
            q = 2097151;
        if (q < -2097152)
            q = -2097152;
        return q;
    endfunction

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] heading_cordic(longint y, longint x);
        logic [31:0] z;
        longint xs, ys;
        logic [31:0] atab [24];
        atab = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                 32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
                 32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
                 32'd166886, 32'd83443, 32'd41722, 32'd20861, 32'd10430,
                 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < NumSteps; i++)
        begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atab[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atab[i];
            end
        end
        return z;
    endfunction

    function automatic heading_t predict_heading(logic [55:0] w);
        heading_t r;
        longint fx, fy, fz;
        logic [31:0] ang;
        logic [32:0] rnd;
        r = '0;
        if (!w[0])
        begin
            r.code = CODE_NOT_READY;
            return r;
        end
        if (w[1])
        begin
            r.code = CODE_OVERFLOW;
            return r;
        end
        fx = scale_axis(w[15:8], w[23:16], 0);
        fy = scale_axis(w[31:24], w[39:32], 1);
        fz = scale_axis(w[47:40], w[55:48], 2);
        ang = heading_cordic(fy, fx);
        rnd = {1'b0, ang} + 33'h8000;
        r.code = CODE_OK;
        r.fx = fx[21:0];
        r.fy = fy[21:0];
        r.fz = fz[21:0];
        r.heading = rnd[31:16] + cal_decl;
        return r;
    endfunction

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // drive sample words; hold a word until it is taken
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_acc))
        begin
            if (tx_gap > 0)
            begin
                tx_gap <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (!calm && ($urandom_range(0, 15) == 0))
            begin
                tx_gap <= $urandom_range(1, 19);
                s_tvalid <= 1'b0;
            end
            else if (sample_q.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= sample_q[0];
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // predict on accept, check results
    always @(posedge clk)
    begin
        heading_t got, want;
        if (rst_n)
        begin
            in_acc = s_tvalid && s_tready;
            if (in_acc)
            begin
                heading_q.push_back(predict_heading(s_tdata));
                void'(sample_q.pop_front());
            end
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[1:0], m_tdata[23:2], m_tdata[45:24],
                       m_tdata[67:46], m_tdata[83:68]};
                if (heading_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word %h", m_tdata);
                end
                else
                begin
                    want = heading_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp code %0d x %h y %h z %h hd %h, got code %0d x %h y %h z %h hd %h",
                                     want.code, want.fx, want.fy, want.fz, want.heading,
                                     got.code, got.fx, got.fy, got.fz, got.heading);
                    end
                end
            end
        end
    end

    // stall the result side
    always @(negedge clk)
    begin
        if (rx_gap > 0)
        begin
            rx_gap <= rx_gap - 1;
            m_tready <= 1'b0;
        end
        else if (!calm && ($urandom_range(0, 15) == 0))
        begin
            rx_gap <= $urandom_range(1, 19);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_RANGE: cal_two_gauss = val[0];
            REG_OFS_X: cal_ofs[0] = val[15:0];
            REG_OFS_Y: cal_ofs[1] = val[15:0];
            REG_OFS_Z: cal_ofs[2] = val[15:0];
            REG_GAIN_X: cal_gain[0] = val[15:0];
            REG_GAIN_Y: cal_gain[1] = val[15:0];
            REG_GAIN_Z: cal_gain[2] = val[15:0];
            default: cal_decl = val[15:0];
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (sample_q.size() != 0 || heading_q.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (NumSteps + 10) @(posedge clk);
    endtask

    function automatic logic [55:0] rand_sample(bit good);
        logic [55:0] w;
        w = 56'({$urandom, $urandom});
        if (good && $urandom_range(0, 9) != 0)
            w[1:0] = 2'b01;
        case ($urandom_range(0, 5))
            0: w[55:8] = {48{w[7]}};
            1: w[23:8] = 16'h0000;
            2: w[39:24] = {w[23:16], w[15:8]};
            default: ;
        endcase
        return w;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            sample_q.push_back(rand_sample(1));
    endtask

    initial
    begin
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        tx_gap = 0;
        rx_gap = 0;
        calm = 0;
        in_acc = 0;
        mismatches = 0;
        cal_two_gauss = 0;
        cal_ofs = '{16'd0, 16'd0, 16'd0};
        cal_gain = '{16'd16384, 16'd16384, 16'd16384};
        cal_decl = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: status cases, extremes, zero field, axis directions
        sample_q.push_back(56'h0);
        sample_q.push_back({48'hFFFF_FFFF_FFFF, 8'hFE});
        sample_q.push_back({48'hFFFF_FFFF_FFFF, 8'h03});
        sample_q.push_back({48'h1234_5678_9ABC, 8'hFF});
        sample_q.push_back({48'h0, 8'h01});
        sample_q.push_back({48'h0, 8'hFD});
        sample_q.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h01});
        sample_q.push_back({16'h8000, 16'h8000, 16'h8000, 8'h01});
        sample_q.push_back({16'h0000, 16'h0000, 16'h0100, 8'h01});
        sample_q.push_back({16'h0000, 16'h0000, 16'hFF00, 8'h01});
        sample_q.push_back({16'h0000, 16'h0100, 16'h0000, 8'h01});
        sample_q.push_back({16'h0000, 16'hFF00, 16'h0000, 8'h01});
        sample_q.push_back({16'h0001, 16'h0001, 16'hFFFF, 8'h01});
        sample_q.push_back({16'hFFFF, 16'h0000, 16'hFFFF, 8'h01});
        drain();

        // extreme calibration: two-gauss, max gains, large offsets
        write_reg(REG_RANGE, 32'd1);
        write_reg(REG_GAIN_X, 32'hFFFF);
        write_reg(REG_GAIN_Y, 32'hFFFF);
        write_reg(REG_GAIN_Z, 32'hFFFF);
        write_reg(REG_OFS_X, 32'h8000);
        write_reg(REG_OFS_Y, 32'h7FFF);
        write_reg(REG_OFS_Z, 32'hFFFF);
        write_reg(REG_DECL, 32'h7FFF);
        sample_q.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h01});
        sample_q.push_back({16'h8000, 16'h8000, 16'h8000, 8'h01});
        random_phase(250);
        drain();

        // range bit cleared with max gain
        write_reg(REG_RANGE, 32'd0);
        write_reg(REG_DECL, 32'h8000);
        random_phase(250);
        drain();

        // zero gain and zero offsets
        write_reg(REG_GAIN_X, 32'd0);
        write_reg(REG_GAIN_Y, 32'd0);
        write_reg(REG_GAIN_Z, 32'd0);
        write_reg(REG_OFS_X, 32'd0);
        write_reg(REG_OFS_Y, 32'd0);
        write_reg(REG_OFS_Z, 32'd0);
        random_phase(100);
        drain();

        // random settings
        for (int ph = 0; ph < 3; ph++)
        begin
            write_reg(REG_RANGE, $urandom);
            write_reg(REG_OFS_X, $urandom);
            write_reg(REG_OFS_Y, $urandom);
            write_reg(REG_OFS_Z, $urandom);
            write_reg(REG_GAIN_X, $urandom);
            write_reg(REG_GAIN_Y, $urandom);
            write_reg(REG_GAIN_Z, $urandom);
            write_reg(REG_DECL, $urandom);
            if (ph == 2)
                calm = 1;
            random_phase(200);
            drain();
        end

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
